// ===== rtl/matrix3x3_inverse_core_assert.svh =====
// Assertion macros used by the checker file of the 3x3 matrix inverse core.
`ifndef MATRIX3X3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3X3_INVERSE_CORE_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define M3I_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define M3I_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/m3i_pkg.sv =====
// Shared types and widths of the 3x3 matrix inverse core.
package m3i_pkg;

   localparam int ELEM_W = 32;
   localparam int THR_W  = 16;
   localparam int N_ELEM = 9;
   // Cofactor magnitude and full-width determinant.
   localparam int COF_W  = 65;
   localparam int DET_W  = 99;
   // Quotient bits before saturation and divider latency.
   localparam int Q_W     = 33;
   localparam int DIV_LAT = Q_W + 2;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic [N_ELEM-1:0][COF_W-1:0] cof_mag;
      logic [N_ELEM-1:0]            cof_neg;
      logic [DET_W-1:0]             det_mag;
      logic                         det_neg;
      logic                         singular;
   } item_type;

endpackage

// ===== rtl/m3i_if.sv =====
// Handshake channels of the 3x3 matrix inverse core.
interface m3i_req_if;
   logic               valid;
   logic               ready;
   m3i_pkg::elem_type  m_r0c0, m_r0c1, m_r0c2;
   m3i_pkg::elem_type  m_r1c0, m_r1c1, m_r1c2;
   m3i_pkg::elem_type  m_r2c0, m_r2c1, m_r2c2;

   modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                   m_r2c0, m_r2c1, m_r2c2, input ready);
   modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                 m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface m3i_rsp_if;
   logic               valid;
   logic               ready;
   m3i_pkg::elem_type  inv_r0c0, inv_r0c1, inv_r0c2;
   m3i_pkg::elem_type  inv_r1c0, inv_r1c1, inv_r1c2;
   m3i_pkg::elem_type  inv_r2c0, inv_r2c1, inv_r2c2;
   logic               invertible;

   modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                   inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, invertible, input ready);
   modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                 inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, invertible, output ready);
endinterface

// ===== rtl/m3i_front.sv =====
// Front pipeline: products, determinant, cofactors and the singular test.
module m3i_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  m3i_pkg::elem_type             m_in [m3i_pkg::N_ELEM],
   input  logic [m3i_pkg::THR_W-1:0]     threshold,
   input  logic                          queue_full,
   output logic                          push,
   output m3i_pkg::item_type             push_item
);

   localparam int COF_W = m3i_pkg::COF_W;
   localparam int DET_W = m3i_pkg::DET_W;
   localparam int THR_W = m3i_pkg::THR_W;
   localparam int N_ELEM = m3i_pkg::N_ELEM;
   localparam int STAGES = 6;

   // Sarrus terms: the first three are added, the last three subtracted.
   localparam int TRI_IDX [6][3] = '{'{0, 4, 8}, '{1, 5, 6}, '{2, 3, 7},
                                     '{0, 5, 7}, '{1, 3, 8}, '{2, 4, 6}};
   // Adjugate entry i is m[a]*m[b] - m[c]*m[d].
   localparam int COF_IDX [9][4] = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                                     '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                                     '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

   logic [STAGES-1:0]         v_ff;
   logic                      fe;

   logic signed [63:0]        ab_ff  [6];
   logic signed [31:0]        c_ff   [6];
   logic signed [63:0]        cpa_ff [N_ELEM];
   logic signed [63:0]        cpb_ff [N_ELEM];
   logic signed [63:0]        hi_ff  [6];
   logic signed [64:0]        lo_ff  [6];
   logic [COF_W-1:0]          cof2_ff [N_ELEM];
   logic [95:0]               t_ff   [6];
   logic [COF_W-1:0]          cof3_ff [N_ELEM];
   logic [DET_W-1:0]          s0_ff, s1_ff;
   logic [COF_W-1:0]          cof4_ff [N_ELEM];
   logic [DET_W-1:0]          det_ff;
   logic [COF_W-1:0]          cof5_ff [N_ELEM];
   m3i_pkg::item_type         item_ff;
   m3i_pkg::item_type         item_in;
   logic [DET_W-1:0]          lim;

   // The whole front stalls together when its last item cannot enter the queue.
   assign fe       = !v_ff[STAGES-1] || !queue_full;
   assign in_ready = fe;
   assign push     = v_ff[STAGES-1] && !queue_full;
   assign push_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (fe) begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < 6; j++) begin : g_tri
      logic signed [31:0] ph;
      logic signed [32:0] pl;
      assign ph = ab_ff[j][63:32];
      assign pl = {1'b0, ab_ff[j][31:0]};
      always_ff @(posedge clock) begin
         if (fe) begin
            ab_ff[j] <= m_in[TRI_IDX[j][0]] * m_in[TRI_IDX[j][1]];
            c_ff[j]  <= m_in[TRI_IDX[j][2]];
            hi_ff[j] <= ph * c_ff[j];
            lo_ff[j] <= pl * c_ff[j];
            t_ff[j]  <= {hi_ff[j], 32'd0} + {{31{lo_ff[j][64]}}, lo_ff[j]};
         end
      end
   end

   for (genvar i = 0; i < N_ELEM; i++) begin : g_cof
      always_ff @(posedge clock) begin
         if (fe) begin
            cpa_ff[i]  <= m_in[COF_IDX[i][0]] * m_in[COF_IDX[i][1]];
            cpb_ff[i]  <= m_in[COF_IDX[i][2]] * m_in[COF_IDX[i][3]];
            cof2_ff[i] <= {cpa_ff[i][63], cpa_ff[i]} - {cpb_ff[i][63], cpb_ff[i]};
            cof3_ff[i] <= cof2_ff[i];
            cof4_ff[i] <= cof3_ff[i];
            cof5_ff[i] <= cof4_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         s0_ff   <= {{3{t_ff[0][95]}}, t_ff[0]} + {{3{t_ff[1][95]}}, t_ff[1]}
                  + {{3{t_ff[2][95]}}, t_ff[2]};
         s1_ff   <= {{3{t_ff[3][95]}}, t_ff[3]} + {{3{t_ff[4][95]}}, t_ff[4]}
                  + {{3{t_ff[5][95]}}, t_ff[5]};
         det_ff  <= s0_ff - s1_ff;
         item_ff <= item_in;
      end
   end

   assign lim = {{(DET_W-THR_W-2*FRAC_BITS){1'b0}}, threshold, {(2*FRAC_BITS){1'b0}}};

   always_comb begin
      item_in.det_neg  = det_ff[DET_W-1];
      item_in.det_mag  = det_ff[DET_W-1] ? (~det_ff + 1'b1) : det_ff;
      // A zero determinant is singular even with a zero threshold.
      item_in.singular = (item_in.det_mag < lim) || (det_ff == '0);
      for (int i = 0; i < N_ELEM; i++) begin
         item_in.cof_neg[i] = cof5_ff[i][COF_W-1];
         item_in.cof_mag[i] = cof5_ff[i][COF_W-1] ? (~cof5_ff[i] + 1'b1) : cof5_ff[i];
      end
   end

endmodule

// ===== rtl/m3i_fifo.sv =====
// Short item queue between the front and back pipelines.
module m3i_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  m3i_pkg::item_type push_data,
   output logic              full,
   input  logic              pop,
   output m3i_pkg::item_type pop_data,
   output logic              empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   m3i_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     cnt_ff;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/m3i_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module m3i_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [m3i_pkg::COF_W-1:0]   num,
   input  logic [m3i_pkg::DET_W-1:0]   den,
   input  logic                        neg,
   input  logic                        kill,
   output m3i_pkg::elem_type           quo
);

   localparam int COF_W = m3i_pkg::COF_W;
   localparam int DET_W = m3i_pkg::DET_W;
   localparam int Q_W   = m3i_pkg::Q_W;
   localparam int CW    = COF_W + 2*FRAC_BITS + DET_W;
   localparam int RW    = DET_W + Q_W;

   logic [CW-1:0]    n_wide, d_top;
   logic [RW-1:0]    rem_ff  [Q_W+1];
   logic [DET_W-1:0] den_ff  [Q_W+1];
   logic [Q_W-1:0]   q_ff    [Q_W+1];
   logic             big_ff  [Q_W+1];
   logic             neg_ff  [Q_W+1];
   logic             kill_ff [Q_W+1];
   m3i_pkg::elem_type quo_ff, quo_in;

   assign n_wide = {{DET_W{1'b0}}, num, {(2*FRAC_BITS){1'b0}}};
   assign d_top  = {{(CW-DET_W-Q_W){1'b0}}, den, {Q_W{1'b0}}};

   // A quotient that does not fit the stage count saturates unless the item is killed.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= n_wide[RW-1:0];
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         big_ff[0]  <= (n_wide >= d_top);
         neg_ff[0]  <= neg;
         kill_ff[0] <= kill;
      end
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_step
      localparam int K = Q_W - s;
      logic [RW-1:0] dk;
      logic          ge;
      assign dk = {{Q_W{1'b0}}, den_ff[s-1]} << K;
      assign ge = (rem_ff[s-1] >= dk);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? (rem_ff[s-1] - dk) : rem_ff[s-1];
            den_ff[s]  <= den_ff[s-1];
            q_ff[s]    <= q_ff[s-1] | ({{(Q_W-1){1'b0}}, ge} << K);
            big_ff[s]  <= big_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            kill_ff[s] <= kill_ff[s-1];
         end
      end
   end

   always_comb begin
      if (kill_ff[Q_W]) begin
         quo_in = '0;
      end else if (neg_ff[Q_W]) begin
         if (big_ff[Q_W] || (q_ff[Q_W] > {2'b01, {(Q_W-2){1'b0}}})) begin
            quo_in = {1'b1, {(m3i_pkg::ELEM_W-1){1'b0}}};
         end else begin
            quo_in = ~q_ff[Q_W][m3i_pkg::ELEM_W-1:0] + 1'b1;
         end
      end else begin
         if (big_ff[Q_W] || (q_ff[Q_W][Q_W-1:Q_W-2] != 2'b00)) begin
            quo_in = {1'b0, {(m3i_pkg::ELEM_W-1){1'b1}}};
         end else begin
            quo_in = q_ff[Q_W][m3i_pkg::ELEM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/m3i_back.sv =====
// Back pipeline: nine dividers in lockstep and the result register.
module m3i_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  m3i_pkg::item_type in_item,
   output logic              pop,
   input  logic              out_ready,
   output logic              out_valid,
   output m3i_pkg::elem_type out_inv [m3i_pkg::N_ELEM],
   output logic              out_invertible
);

   localparam int L = m3i_pkg::DIV_LAT;

   logic [L-1:0] vld_ff;
   logic [L-1:0] sing_ff;
   logic         be;

   assign be        = !vld_ff[L-1] || out_ready;
   assign pop       = be && in_valid;
   assign out_valid = vld_ff[L-1];
   assign out_invertible = !sing_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (be) begin
         vld_ff <= {vld_ff[L-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         sing_ff <= {sing_ff[L-2:0], in_item.singular};
      end
   end

   for (genvar i = 0; i < m3i_pkg::N_ELEM; i++) begin : g_lane
      m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (be),
         .num   (in_item.cof_mag[i]),
         .den   (in_item.det_mag),
         .neg   (in_item.cof_neg[i] ^ in_item.det_neg),
         .kill  (in_item.singular),
         .quo   (out_inv[i])
      );
   end

endmodule

// ===== rtl/matrix3x3_inverse_core.sv =====
// Throughput: one matrix per cycle when the result side does not stall; six front
// stages, the item queue, then a 35-stage divider that retires one quotient bit
// per stage in nine lanes.
// A four-entry queue between front and back absorbs result-side stalls.
// Reset is synchronous and active high; it empties the pipelines and queue
// and sets singular_threshold to 1.
module matrix3x3_inverse_core #(
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [m3i_pkg::THR_W-1:0]  csr_wdata,
   m3i_req_if.sink                    req_if,
   m3i_rsp_if.source                  rsp_if
);

   logic [m3i_pkg::THR_W-1:0] thr_ff;
   m3i_pkg::elem_type         m_in [m3i_pkg::N_ELEM];
   m3i_pkg::elem_type         inv  [m3i_pkg::N_ELEM];
   m3i_pkg::item_type         push_item, head_item;
   logic                      push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= m3i_pkg::THR_W'(1);
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign m_in[0] = req_if.m_r0c0;
   assign m_in[1] = req_if.m_r0c1;
   assign m_in[2] = req_if.m_r0c2;
   assign m_in[3] = req_if.m_r1c0;
   assign m_in[4] = req_if.m_r1c1;
   assign m_in[5] = req_if.m_r1c2;
   assign m_in[6] = req_if.m_r2c0;
   assign m_in[7] = req_if.m_r2c1;
   assign m_in[8] = req_if.m_r2c2;

   m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .m_in       (m_in),
      .threshold  (thr_ff),
      .queue_full (full),
      .push       (push),
      .push_item  (push_item)
   );

   m3i_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_item),
      .full      (full),
      .pop       (pop),
      .pop_data  (head_item),
      .empty     (empty)
   );

   m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (!empty),
      .in_item        (head_item),
      .pop            (pop),
      .out_ready      (rsp_if.ready),
      .out_valid      (rsp_if.valid),
      .out_inv        (inv),
      .out_invertible (rsp_if.invertible)
   );

   assign rsp_if.inv_r0c0 = inv[0];
   assign rsp_if.inv_r0c1 = inv[1];
   assign rsp_if.inv_r0c2 = inv[2];
   assign rsp_if.inv_r1c0 = inv[3];
   assign rsp_if.inv_r1c1 = inv[4];
   assign rsp_if.inv_r1c2 = inv[5];
   assign rsp_if.inv_r2c0 = inv[6];
   assign rsp_if.inv_r2c1 = inv[7];
   assign rsp_if.inv_r2c2 = inv[8];

endmodule

// ===== rtl/m3i_checker.sv =====
// Port-level checker for the 3x3 matrix inverse core, bound to the top level.
`include "matrix3x3_inverse_core_assert.svh"

module m3i_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_invertible,
   input logic [m3i_pkg::ELEM_W-1:0]  rsp_or
);

   logic [7:0] outstanding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 8'(req_valid && req_ready)
                           - 8'(rsp_valid && rsp_ready);
      end
   end

   `M3I_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "result after reset")
   `M3I_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
   `M3I_ASSERT(a_no_phantom, clock, reset, rsp_valid |-> outstanding_ff != 8'd0, "extra item")
   `M3I_ASSERT(a_singular_zero, clock, reset, rsp_valid && !rsp_invertible |-> rsp_or == '0, "singular nonzero")

endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_invertible (rsp_if.invertible),
   .rsp_or         (rsp_if.inv_r0c0 | rsp_if.inv_r0c1 | rsp_if.inv_r0c2 |
                    rsp_if.inv_r1c0 | rsp_if.inv_r1c1 | rsp_if.inv_r1c2 |
                    rsp_if.inv_r2c0 | rsp_if.inv_r2c1 | rsp_if.inv_r2c2)
);
